// File: src/rtap_pkg.sv
`default_nettype none
package rtap_pkg;

    localparam int CordicSteps = 16;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_PREDICT = 2'd1,
        REQ_LIST    = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [0:0] {
        CFG_COUNT  = 1'd0,
        CFG_HEIGHT = 1'd1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED_X,
        ST_PRED_Y,
        ST_PRED_Z,
        ST_PRED_YAW,
        ST_ARM_START,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_OUT
    } state_t;

    function automatic logic signed [33:0] atan_turn(input logic [3:0] k);
        logic signed [33:0] v;
        case (k)
            4'd0:  v = 34'sd536870912;
            4'd1:  v = 34'sd316933406;
            4'd2:  v = 34'sd167458907;
            4'd3:  v = 34'sd85004756;
            4'd4:  v = 34'sd42667331;
            4'd5:  v = 34'sd21354465;
            4'd6:  v = 34'sd10679838;
            4'd7:  v = 34'sd5340245;
            4'd8:  v = 34'sd2670163;
            4'd9:  v = 34'sd1335087;
            4'd10: v = 34'sd667544;
            4'd11: v = 34'sd333772;
            4'd12: v = 34'sd166886;
            4'd13: v = 34'sd83443;
            4'd14: v = 34'sd41722;
            default: v = 34'sd20861;
        endcase
        return v;
    endfunction

    // Angle of plate i for n plates: floor(i * 65536 / n), for n up to eight.
    function automatic logic [15:0] armor_offset(input logic [3:0] n, input logic [2:0] i);
        logic [15:0] v;
        case ({n, i})
            {4'd2, 3'd1}: v = 16'd32768;
            {4'd3, 3'd1}: v = 16'd21845;
            {4'd3, 3'd2}: v = 16'd43690;
            {4'd4, 3'd1}: v = 16'd16384;
            {4'd4, 3'd2}: v = 16'd32768;
            {4'd4, 3'd3}: v = 16'd49152;
            {4'd5, 3'd1}: v = 16'd13107;
            {4'd5, 3'd2}: v = 16'd26214;
            {4'd5, 3'd3}: v = 16'd39321;
            {4'd5, 3'd4}: v = 16'd52428;
            {4'd6, 3'd1}: v = 16'd10922;
            {4'd6, 3'd2}: v = 16'd21845;
            {4'd6, 3'd3}: v = 16'd32768;
            {4'd6, 3'd4}: v = 16'd43690;
            {4'd6, 3'd5}: v = 16'd54613;
            {4'd7, 3'd1}: v = 16'd9362;
            {4'd7, 3'd2}: v = 16'd18724;
            {4'd7, 3'd3}: v = 16'd28086;
            {4'd7, 3'd4}: v = 16'd37449;
            {4'd7, 3'd5}: v = 16'd46811;
            {4'd7, 3'd6}: v = 16'd56173;
            {4'd8, 3'd1}: v = 16'd8192;
            {4'd8, 3'd2}: v = 16'd16384;
            {4'd8, 3'd3}: v = 16'd24576;
            {4'd8, 3'd4}: v = 16'd32768;
            {4'd8, 3'd5}: v = 16'd40960;
            {4'd8, 3'd6}: v = 16'd49152;
            {4'd8, 3'd7}: v = 16'd57344;
            default:      v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/rotating_target_armor_predictor.sv
`default_nettype none
// Load and unknown requests end on acceptance; predict does one multiply per cycle.
// Per armor, a list request runs ARM_START, the iterative CORDIC unit, MUL_X and MUL_Y on
// the shared multiplier and OUT to present the word, which output stalls can hold.
// Only one request is in flight; in_stall is high until its last word is taken.
// Reset clears the target state to zero, count_reg to 4 and height_reg to zero.
module rotating_target_armor_predictor #(
    parameter int MAX_ARMORS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic signed [31:0] vel_z,
    input  wire logic signed [15:0] heading,
    input  wire logic signed [31:0] heading_rate,
    input  wire logic [30:0]        radius_a,
    input  wire logic [30:0]        radius_b,
    input  wire logic [15:0]        step_dt,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      armor_x,
    output logic signed [31:0]      armor_y,
    output logic signed [31:0]      armor_z,
    output logic signed [15:0]      armor_yaw,
    output logic [1:0]              armor_index,
    output logic                    last_armor
);
    localparam int IW = $clog2(MAX_ARMORS + 1);

    rtap_pkg::state_t state_reg, state_next;
    logic [2:0] count_reg;
    logic signed [31:0] height_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg, vx_reg, vy_reg, vz_reg, ys_reg;
    logic [15:0] yaw_reg;
    logic signed [32:0] rad_reg, rdel_reg;
    logic [15:0] dt_reg;
    logic [IW-1:0] i_reg, n_reg;
    logic [15:0] ang_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic [IW-1:0] n_eff;
    logic [15:0] offs;
    logic [15:0] ang_next;
    logic alt;
    logic signed [33:0] r_cur;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] prod;
    logic signed [33:0] cos_v, sin_v;
    logic c_start, c_done;
    logic signed [65:0] sum;
    logic in_acc;

    assign in_acc = in_valid && !in_stall;
    assign in_stall = state_reg != rtap_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (count_reg == 3'd0)
            n_eff = IW'(4 > MAX_ARMORS ? MAX_ARMORS : 4);
        else if (32'(count_reg) > MAX_ARMORS)
            n_eff = IW'(MAX_ARMORS);
        else
            n_eff = IW'(count_reg);
    end

    // The armor offset is a small constant table indexed by plate and count.
    always_comb
    begin
        offs = rtap_pkg::armor_offset(4'(n_reg), 3'(i_reg));
        ang_next = yaw_reg + offs;
        alt = (n_reg == IW'(4)) && (i_reg == IW'(1) || i_reg == IW'(3));
        r_cur = alt ? 34'(rad_reg + rdel_reg) : 34'(rad_reg);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = {18'd0, dt_reg};
        case (state_reg)
            rtap_pkg::ST_PRED_X:   mul_a = 34'(vx_reg);
            rtap_pkg::ST_PRED_Y:   mul_a = 34'(vy_reg);
            rtap_pkg::ST_PRED_Z:   mul_a = 34'(vz_reg);
            rtap_pkg::ST_PRED_YAW: mul_a = 34'(ys_reg);
            rtap_pkg::ST_MUL_X:
            begin
                mul_a = r_cur;
                mul_b = cos_v;
            end
            rtap_pkg::ST_MUL_Y:
            begin
                mul_a = r_cur;
                mul_b = sin_v;
            end
            default: mul_a = '0;
        endcase
        prod = mul_a * mul_b;
    end

    assign c_start = state_reg == rtap_pkg::ST_ARM_START;

    rtap_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (c_start),
        .angle   (ang_next),
        .done    (c_done),
        .cos_q30 (cos_v),
        .sin_q30 (sin_v)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtap_pkg::ST_IDLE:
                if (in_acc)
                begin
                    if (req_type == rtap_pkg::REQ_PREDICT)
                        state_next = rtap_pkg::ST_PRED_X;
                    else if (req_type == rtap_pkg::REQ_LIST)
                        state_next = rtap_pkg::ST_ARM_START;
                end
            rtap_pkg::ST_PRED_X:   state_next = rtap_pkg::ST_PRED_Y;
            rtap_pkg::ST_PRED_Y:   state_next = rtap_pkg::ST_PRED_Z;
            rtap_pkg::ST_PRED_Z:   state_next = rtap_pkg::ST_PRED_YAW;
            rtap_pkg::ST_PRED_YAW: state_next = rtap_pkg::ST_IDLE;
            rtap_pkg::ST_ARM_START: state_next = rtap_pkg::ST_CORDIC;
            rtap_pkg::ST_CORDIC:   if (c_done) state_next = rtap_pkg::ST_MUL_X;
            rtap_pkg::ST_MUL_X:    state_next = rtap_pkg::ST_MUL_Y;
            rtap_pkg::ST_MUL_Y:    state_next = rtap_pkg::ST_OUT;
            rtap_pkg::ST_OUT:
                if (!out_stall)
                    state_next = (i_reg == n_reg - IW'(1)) ? rtap_pkg::ST_IDLE
                                                           : rtap_pkg::ST_ARM_START;
            default: state_next = rtap_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        sum = '0;
        case (state_reg)
            rtap_pkg::ST_PRED_X: sum = 66'(cx_reg) + 66'(prod >>> 16);
            rtap_pkg::ST_PRED_Y: sum = 66'(cy_reg) + 66'(prod >>> 16);
            rtap_pkg::ST_PRED_Z: sum = 66'(cz_reg) + 66'(prod >>> 16);
            rtap_pkg::ST_MUL_X:
                sum = 66'(cx_reg) - 66'((prod + 68'sd536870912) >>> 30);
            rtap_pkg::ST_MUL_Y:
                sum = 66'(cy_reg) - 66'((prod + 68'sd536870912) >>> 30);
            default: sum = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtap_pkg::ST_IDLE;
            count_reg <= 3'd4;
            height_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
            vz_reg <= '0;
            ys_reg <= '0;
            yaw_reg <= '0;
            rad_reg <= '0;
            rdel_reg <= '0;
            i_reg <= '0;
            n_reg <= IW'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rtap_pkg::CFG_COUNT)
                    count_reg <= cfg_data[2:0];
                else
                    height_reg <= cfg_data;
            end
            case (state_reg)
                rtap_pkg::ST_IDLE:
                    if (in_acc && req_type == rtap_pkg::REQ_LOAD)
                    begin
                        cx_reg <= pos_x;
                        cy_reg <= pos_y;
                        cz_reg <= pos_z;
                        vx_reg <= vel_x;
                        vy_reg <= vel_y;
                        vz_reg <= vel_z;
                        yaw_reg <= heading;
                        ys_reg <= heading_rate;
                        rad_reg <= {2'b0, radius_a};
                        rdel_reg <= 33'({2'b0, radius_b}) - 33'({2'b0, radius_a});
                    end
                    else if (in_acc && req_type == rtap_pkg::REQ_LIST)
                    begin
                        i_reg <= '0;
                        n_reg <= n_eff;
                    end
                rtap_pkg::ST_PRED_X:   cx_reg <= rtap_pkg::sat32(sum);
                rtap_pkg::ST_PRED_Y:   cy_reg <= rtap_pkg::sat32(sum);
                rtap_pkg::ST_PRED_Z:   cz_reg <= rtap_pkg::sat32(sum);
                rtap_pkg::ST_PRED_YAW: yaw_reg <= yaw_reg + prod[31:16];
                rtap_pkg::ST_OUT:
                    if (!out_stall)
                        i_reg <= i_reg + IW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            dt_reg <= step_dt;
        if (state_reg == rtap_pkg::ST_ARM_START)
        begin
            ang_reg <= ang_next;
            oz_reg <= alt ? rtap_pkg::sat32(66'(cz_reg) + 66'(height_reg)) : cz_reg;
        end
        if (state_reg == rtap_pkg::ST_MUL_X)
            ox_reg <= rtap_pkg::sat32(sum);
        if (state_reg == rtap_pkg::ST_MUL_Y)
            oy_reg <= rtap_pkg::sat32(sum);
    end

    assign out_valid = state_reg == rtap_pkg::ST_OUT;
    assign armor_x = ox_reg;
    assign armor_y = oy_reg;
    assign armor_z = oz_reg;
    assign armor_yaw = ang_reg;
    assign armor_index = 2'(i_reg);
    assign last_armor = i_reg == n_reg - IW'(1);

    a_out_only_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result word shown while input open");
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> i_reg < n_reg)
        else $error("armor index past count");
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(armor_x) && $stable(armor_y))
        else $error("stalled word changed");

endmodule
`default_nettype wire

// File: src/rtap_cordic.sv
`default_nettype none
// Iterative CORDIC: one rotation step per cycle, sixteen steps, Q30 outputs.
module rtap_cordic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [15:0]        angle,
    output logic                    done,
    output logic signed [33:0]      cos_q30,
    output logic signed [33:0]      sin_q30
);
    logic signed [33:0] x_reg, y_reg, z_reg, x_next, y_next, z_next;
    logic [3:0] k_reg, k_next;
    logic busy_reg, busy_next, flip_reg, flip_next, done_reg, done_next;
    logic signed [33:0] z0, zf;

    always_comb
    begin
        z0 = {{2{angle[15]}}, angle, 16'd0};
        zf = z0;
        flip_next = flip_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        k_next = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            flip_next = 1'b0;
            if (z0 > 34'sd1073741824 || z0 < -34'sd1073741824)
            begin
                zf = {{2{~angle[15]}}, ~angle[15], angle[14:0], 16'd0};
                flip_next = 1'b1;
            end
            x_next = rtap_pkg::CordicGain;
            y_next = '0;
            z_next = zf;
            k_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - (y_reg >>> k_reg);
                y_next = y_reg + (x_reg >>> k_reg);
                z_next = z_reg - rtap_pkg::atan_turn(k_reg);
            end
            else
            begin
                x_next = x_reg + (y_reg >>> k_reg);
                y_next = y_reg - (x_reg >>> k_reg);
                z_next = z_reg + rtap_pkg::atan_turn(k_reg);
            end
            k_next = k_reg + 4'd1;
            if (k_reg == 4'(rtap_pkg::CordicSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg <= '0;
            flip_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg <= k_next;
            flip_reg <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = done_reg;
    assign cos_q30 = flip_reg ? -x_reg : x_reg;
    assign sin_q30 = flip_reg ? -y_reg : y_reg;

endmodule
`default_nettype wire

// File: tb/tb_rotating_target_armor_predictor.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_rotating_target_armor_predictor;

    localparam int HoldLength = 300;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] yaw;
        logic [1:0]         index;
        logic               last;
    } armor_word_t;

    typedef struct packed {
        rtap_pkg::req_t     kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [15:0] hd;
        logic signed [31:0] hr;
        logic [30:0]        ra;
        logic [30:0]        rb;
        logic [15:0]        dt;
    } request_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] req_type;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading_rate;
    logic signed [15:0] heading;
    logic [30:0] radius_a, radius_b;
    logic [15:0] step_dt;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [31:0] cfg_data;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] armor_x, armor_y, armor_z;
    logic signed [15:0] armor_yaw;
    logic [1:0] armor_index;
    logic last_armor;

    rotating_target_armor_predictor u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .heading(heading),
        .heading_rate(heading_rate), .radius_a(radius_a), .radius_b(radius_b),
        .step_dt(step_dt), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid),
        .out_stall(out_stall), .armor_x(armor_x), .armor_y(armor_y),
        .armor_z(armor_z), .armor_yaw(armor_yaw), .armor_index(armor_index),
        .last_armor(last_armor)
    );

    // Predictor copy of the target state and registers.
    logic [2:0]         plate_count;
    logic signed [63:0] lift;
    logic signed [63:0] cx, cy, cz, sx, sy, sz, spin, rbase, rdelta;
    logic [15:0]        yaw_now;

    armor_word_t plates_due[$];
    int errors;
    int words_seen;
    int idle_cycles;
    int hold_cycles;
    bit hold_request;
    bit hold_done;
    bit stall_random;
    bit burst_mode;
    int requests_sent;
    int lists_sent;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v,
                                                       input int k);
        return v >>> k;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] wrap32(input logic signed [63:0] v);
        logic [31:0] b;
        b = v[31:0];
        return $signed(b);
    endfunction

    task automatic rotate(input logic [15:0] ang, output logic signed [63:0] c,
                          output logic signed [63:0] s);
        logic signed [63:0] z, x, y, dx, dy;
        logic signed [63:0] steps[16];
        bit flip;
        steps = '{64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
                  64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
                  64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
                  64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861};
        z = wrap32({32'd0, ang, 16'd0});
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824 || z < -64'sd1073741824)
        begin
            z = wrap32(z - 64'sd2147483648);
            flip = 1'b1;
        end
        for (int k = 0; k < 16; k++)
        begin
            dx = floor_shift(y, k);
            dy = floor_shift(x, k);
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - steps[k];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + steps[k];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic model_request(input request_t r);
        int n;
        logic [15:0] ang;
        logic signed [63:0] rad, c, s, v;
        armor_word_t w;
        bit alt;
        case (r.kind)
            rtap_pkg::REQ_LOAD:
            begin
                cx = r.px; cy = r.py; cz = r.pz;
                sx = r.vx; sy = r.vy; sz = r.vz;
                yaw_now = r.hd;
                spin = r.hr;
                rbase = {33'd0, r.ra};
                rdelta = $signed({33'd0, r.rb}) - $signed({33'd0, r.ra});
            end
            rtap_pkg::REQ_PREDICT:
            begin
                cx = clamp32(cx + floor_shift(sx * $signed({48'd0, r.dt}), 16));
                cy = clamp32(cy + floor_shift(sy * $signed({48'd0, r.dt}), 16));
                cz = clamp32(cz + floor_shift(sz * $signed({48'd0, r.dt}), 16));
                c = floor_shift(spin * $signed({48'd0, r.dt}), 16);
                yaw_now = yaw_now + c[15:0];
            end
            rtap_pkg::REQ_LIST:
            begin
                n = (plate_count == 0) ? 4 : plate_count;
                if (n > 4)
                    n = 4;
                for (int i = 0; i < n; i++)
                begin
                    ang = yaw_now + 16'((i * 65536) / n);
                    alt = (n == 4) && (i == 1 || i == 3);
                    rad = alt ? rbase + rdelta : rbase;
                    rotate(ang, c, s);
                    v = clamp32(cx - floor_shift(rad * c + 64'sd536870912, 30));
                    w.x = v[31:0];
                    v = clamp32(cy - floor_shift(rad * s + 64'sd536870912, 30));
                    w.y = v[31:0];
                    v = clamp32(alt ? cz + lift : cz);
                    w.z = v[31:0];
                    w.yaw = ang;
                    w.index = i[1:0];
                    w.last = (i == n - 1);
                    plates_due.insert(plates_due.size(), w);
                end
                lists_sent++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_request(input request_t r);
        if (burst_mode && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.kind;
        pos_x <= r.px; pos_y <= r.py; pos_z <= r.pz;
        vel_x <= r.vx; vel_y <= r.vy; vel_z <= r.vz;
        heading <= r.hd; heading_rate <= r.hr;
        radius_a <= r.ra; radius_b <= r.rb; step_dt <= r.dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model_request(r);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic write_register(input rtap_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == rtap_pkg::CFG_COUNT)
            plate_count = value[2:0];
        else
            lift = $signed(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (plates_due.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic request_t random_request(input rtap_pkg::req_t kind);
        request_t r;
        r.kind = kind;
        r.px = $urandom; r.py = $urandom; r.pz = $urandom;
        r.vx = $urandom; r.vy = $urandom; r.vz = $urandom;
        r.hd = 16'($urandom); r.hr = $urandom;
        r.ra = 31'($urandom); r.rb = 31'($urandom); r.dt = 16'($urandom);
        if ($urandom_range(0, 2) != 0)
        begin
            r.px = $signed(r.px) >>> $urandom_range(0, 31);
            r.py = $signed(r.py) >>> $urandom_range(0, 31);
            r.pz = $signed(r.pz) >>> $urandom_range(0, 31);
            r.vx = $signed(r.vx) >>> $urandom_range(0, 31);
            r.vy = $signed(r.vy) >>> $urandom_range(0, 31);
            r.vz = $signed(r.vz) >>> $urandom_range(0, 31);
            r.ra = r.ra >> $urandom_range(0, 30);
            r.rb = r.rb >> $urandom_range(0, 30);
        end
        return r;
    endfunction

    task automatic test_reset_state;
        send_request(random_request(rtap_pkg::REQ_LIST));
        drain();
    endtask

    task automatic test_extremes;
        request_t r;
        r = random_request(rtap_pkg::REQ_LOAD);
        r.px = 32'sh7fffffff; r.py = 32'sh80000000; r.pz = 32'sh7fffffff;
        r.vx = 32'sh7fffffff; r.vy = 32'sh80000000; r.vz = 32'sh7fffffff;
        r.hd = 16'sh7fff; r.hr = 32'sh80000000;
        r.ra = 31'h7fffffff; r.rb = 31'h0;
        send_request(r);
        send_request(random_request(rtap_pkg::REQ_LIST));
        r.kind = rtap_pkg::REQ_PREDICT;
        r.dt = 16'hffff;
        send_request(r);
        send_request(random_request(rtap_pkg::REQ_LIST));
        r = random_request(rtap_pkg::REQ_LOAD);
        r.px = 32'sh80000000; r.py = 32'sh7fffffff; r.pz = 32'sh80000000;
        r.hd = 16'sh8000; r.hr = 32'sh7fffffff; r.ra = 31'h0; r.rb = 31'h7fffffff;
        send_request(r);
        send_request(random_request(rtap_pkg::REQ_LIST));
        r.kind = rtap_pkg::REQ_PREDICT;
        r.dt = 16'h0;
        send_request(r);
        r.kind = rtap_pkg::REQ_NONE;
        send_request(r);
        send_request(random_request(rtap_pkg::REQ_LIST));
        drain();
    endtask

    task automatic test_counts;
        logic [31:0] heights[3];
        heights = '{32'h7fffffff, 32'h80000000, 32'h00018000};
        for (int c = 0; c < 8; c++)
        begin
            write_register(rtap_pkg::CFG_COUNT, c);
            write_register(rtap_pkg::CFG_HEIGHT, heights[c % 3]);
            send_request(random_request(rtap_pkg::REQ_LOAD));
            send_request(random_request(rtap_pkg::REQ_LIST));
            drain();
        end
    endtask

    task automatic test_random;
        request_t r;
        int pick;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_register(rtap_pkg::CFG_COUNT, $urandom_range(0, 7));
            write_register(rtap_pkg::CFG_HEIGHT, $urandom);
            burst_mode = (phase != 1);
            for (int k = 0; k < 70; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    r = random_request(rtap_pkg::REQ_LOAD);
                else if (pick < 5)
                    r = random_request(rtap_pkg::REQ_PREDICT);
                else if (pick < 9)
                    r = random_request(rtap_pkg::REQ_LIST);
                else
                    r = random_request(rtap_pkg::REQ_NONE);
                send_request(r);
            end
            drain();
        end
        burst_mode = 1'b1;
    endtask

    task automatic test_backpressure;
        hold_request = 1'b1;
        for (int k = 0; k < 5; k++)
            send_request(random_request(rtap_pkg::REQ_LIST));
        drain();
        for (int k = 0; k < 4; k++)
        begin
            send_request(random_request(rtap_pkg::REQ_PREDICT));
            send_request(random_request(rtap_pkg::REQ_LIST));
            drain();
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HoldLength - 1)
                hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (stall_random)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        armor_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (plates_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word x=%0d y=%0d", $time, armor_x, armor_y);
            end
            else
            begin
                want = plates_due.pop_front();
                if (armor_x !== want.x || armor_y !== want.y || armor_z !== want.z
                    || armor_yaw !== want.yaw || armor_index !== want.index
                    || last_armor !== want.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected x=%0d y=%0d z=%0d yaw=%0d idx=%0d last=%0b",
                             $time, want.x, want.y, want.z, want.yaw, want.index, want.last);
                    $display("%0t:          actual x=%0d y=%0d z=%0d yaw=%0d idx=%0d last=%0b",
                             $time, armor_x, armor_y, armor_z, armor_yaw, armor_index,
                             last_armor);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        requests_sent = 0; lists_sent = 0;
        stall_random = 1'b1; burst_mode = 1'b1;
        plate_count = 3'd4; lift = 0;
        cx = 0; cy = 0; cz = 0; sx = 0; sy = 0; sz = 0;
        spin = 0; rbase = 0; rdelta = 0; yaw_now = '0;
        rst_n = 1'b0; in_valid = 1'b0; req_type = rtap_pkg::REQ_NONE;
        pos_x = '0; pos_y = '0; pos_z = '0; vel_x = '0; vel_y = '0; vel_z = '0;
        heading = '0; heading_rate = '0; radius_a = '0; radius_b = '0; step_dt = '0;
        cfg_valid = 1'b0; cfg_index = rtap_pkg::CFG_COUNT; cfg_data = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_state();
        test_extremes();
        test_counts();
        test_random();
        test_backpressure();
        drain();
        $display("Sent %0d requests including %0d list requests; checked %0d armor words.",
                 requests_sent, lists_sent, words_seen);
        $display("Covered all plate counts, height extremes, saturation and output stalls.");
        if (errors == 0 && plates_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
